FILE: sv/fp8c_pkg.sv
package fp8c_pkg;

	typedef enum logic [1:0] {
		MODE_ENC_E4M3 = 2'd0,
		MODE_ENC_E5M2 = 2'd1,
		MODE_DEC_E4M3 = 2'd2,
		MODE_DEC_E5M2 = 2'd3
	} mode_t;

	localparam logic [7:0] E4M3_NAN     = 8'hFF;
	localparam logic [7:0] E4M3_INF     = 8'h7E;
	localparam logic [7:0] E4M3_MAXCODE = 8'h77;
	localparam logic [7:0] E5M2_NAN     = 8'h7F;
	localparam logic [7:0] E5M2_INF     = 8'h7C;
	localparam logic [7:0] E5M2_MAXCODE = 8'h7B;
	localparam logic [31:0] FP32_QNAN   = 32'h7FC00000;
	localparam logic [30:0] FP32_INF    = 31'h7F800000;

	// stage 1 -> stage 2 record of an encode item
	typedef struct packed {
		logic        sign;
		logic        special;   // zero, NaN, inf or saturate: code fixed
		logic [6:0]  fixed;     // magnitude code when special
		logic [23:0] m;         // significand
		logic [5:0]  shift;     // right shift, clipped to 63
		logic [4:0]  ebase;     // (eb - emin) exponent code
	} enc_s1_t;

endpackage

FILE: sv/fp8_float_converter.sv
// done follows start through the v_s1, v_s2 and v_s3 registers; throughput: one item per cycle.
// busy is held low: a new item may start every cycle, results never stall.
// Stages: s1 decode/exponent prep, s2 shift, round, saturate and pack, s3 output select.
// arst_n clears all valid bits; payload registers are not reset.
module fp8_float_converter
	import fp8c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] value_in,
	output logic        done,
	output logic [31:0] value_out
);
	logic        v_s1, v_s2, v_s3;
	logic        enc_s1, enc_s2, e5_s1;
	enc_s1_t     rec_w, rec_s1;
	logic [31:0] dec_w, dec_s1, dec_s2;
	logic [7:0]  code_s2;
	logic [31:0] out_s3;
	logic        is_enc, is_e5;
	logic [24:0] q;
	logic [63:0] mm, rem, half;
	logic [7:0]  sum;
	logic [6:0]  maxc;

	function automatic logic [6:0] maxc_min(input logic [7:0] s, input logic [6:0] mx);
		maxc_min = (s > {1'b0, mx}) ? mx : s[6:0];
	endfunction

	assign busy = 1'b0;
	assign is_enc = (mode == MODE_ENC_E4M3) || (mode == MODE_ENC_E5M2);
	assign is_e5 = (mode == MODE_ENC_E5M2) || (mode == MODE_DEC_E5M2);

	fp8c_enc_prep u_prep (.e5(is_e5), .x(value_in), .rec(rec_w));
	fp8c_decode u_dec (.e5(is_e5), .code(value_in[7:0]), .result(dec_w));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		enc_s1 <= is_enc;
		e5_s1 <= is_e5;
		rec_s1 <= rec_w;
		dec_s1 <= dec_w;
		enc_s2 <= enc_s1;
		dec_s2 <= dec_s1;
		code_s2 <= {rec_s1.sign, (rec_s1.special ? rec_s1.fixed : maxc_min(sum, maxc))};
		out_s3 <= enc_s2 ? {24'd0, code_s2} : dec_s2;
	end

	// round to nearest, ties toward zero
	always_comb begin
		mm = {40'd0, rec_s1.m};
		q = 25'(mm >> rec_s1.shift);
		rem = mm & ((64'd1 << rec_s1.shift) - 64'd1);
		half = (rec_s1.shift == 6'd0) ? 64'd0 : (64'd1 << (rec_s1.shift - 6'd1));
		if (rec_s1.shift != 6'd0 && rem > half)
			q = q + 25'd1;
		maxc = e5_s1 ? E5M2_MAXCODE[6:0] : E4M3_MAXCODE[6:0];
		sum = (e5_s1 ? {1'b0, rec_s1.ebase, 2'd0} : {rec_s1.ebase, 3'd0})
			+ ((q > 25'd255) ? 8'd255 : q[7:0]);
	end

	assign done = v_s3;
	assign value_out = out_s3;

`ifndef SYNTHESIS
	a_lat: assert property (@(posedge clk) disable iff (!arst_n) start |-> ##3 done)
		else $error("item lost in pipeline");
	a_enc_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && enc_s2) |=> (value_out[31:8] == 24'd0))
		else $error("encode result upper bits set");
	a_nostart: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start, 3) |-> !done)
		else $error("spurious done");
`endif
endmodule

FILE: sv/fp8c_decode.sv
module fp8c_decode
	import fp8c_pkg::*;
(
	input  logic       e5,
	input  logic [7:0] code,
	output logic [31:0] result
);
	logic       sign;
	logic [4:0] ex;
	logic [2:0] mant;
	logic [1:0] p;
	logic [7:0] exp32;
	logic [22:0] frac;

	always_comb begin
		sign = code[7];
		if (e5) begin
			ex = code[6:2];
			mant = {1'b0, code[1:0]};
		end else begin
			ex = {1'b0, code[6:3]};
			mant = code[2:0];
		end
		p = mant[2] ? 2'd2 : (mant[1] ? 2'd1 : 2'd0);
		exp32 = '0;
		frac = '0;
		result = '0;
		if (e5 && ex == 5'h1F) begin
			result = (mant == 3'd0) ? {sign, FP32_INF} : FP32_QNAN;
		end else if (!e5 && ex == 5'h0F) begin
			result = (mant == 3'd6) ? {sign, FP32_INF} : FP32_QNAN;
		end else if (ex == 5'd0) begin
			if (mant == 3'd0) begin
				result = {sign, 31'd0};
			end else begin
				// subnormal: 2^(p - bias + 1 - mb)
				exp32 = e5 ? (8'd111 + {6'd0, p}) : (8'd118 + {6'd0, p});
				frac = {20'd0, mant ^ (3'd1 << p)} << (5'd23 - {3'd0, p});
				result = {sign, exp32, frac};
			end
		end else begin
			exp32 = e5 ? ({3'd0, ex} + 8'd112) : ({3'd0, ex} + 8'd120);
			frac = e5 ? {mant[1:0], 21'd0} : {mant, 20'd0};
			result = {sign, exp32, frac};
		end
	end
endmodule

FILE: sv/fp8c_enc_prep.sv
module fp8c_enc_prep
	import fp8c_pkg::*;
(
	input  logic        e5,
	input  logic [31:0] x,
	output enc_s1_t     rec
);
	logic [7:0] e;
	logic [22:0] f;
	logic [9:0] ebits, eb, sh;   // eb is biased by 127
	logic [7:0] eminb;

	always_comb begin
		e = x[30:23];
		f = x[22:0];
		rec = '0;
		rec.sign = x[31];
		ebits = (e == 8'd0) ? 10'd1 : {2'd0, e};
		eminb = e5 ? 8'd113 : 8'd121;       // emin + 127
		eb = ({2'd0, e} < {2'd0, eminb}) ? {2'd0, eminb} : {2'd0, e};
		// shift = eb - mb - ebits + 23 ; eb,ebits both biased
		sh = eb + (e5 ? 10'd21 : 10'd20) - ebits;
		rec.m = (e == 8'd0) ? {1'b0, f} : {1'b1, f};
		rec.shift = (sh > 10'd63) ? 6'd63 : sh[5:0];
		rec.ebase = 5'(eb - {2'd0, eminb});
		if (e == 8'hFF) begin
			rec.special = 1'b1;
			if (f != 23'd0) begin
				// NaN code is fixed, sign included
				rec.sign = e5 ? E5M2_NAN[7] : E4M3_NAN[7];
				rec.fixed = e5 ? E5M2_NAN[6:0] : E4M3_NAN[6:0];
			end else begin
				rec.fixed = e5 ? E5M2_INF[6:0] : E4M3_INF[6:0];
			end
		end else if (e == 8'd0 && f == 23'd0) begin
			rec.special = 1'b1;
		end else if (e > (e5 ? 8'd142 : 8'd134)) begin
			rec.special = 1'b1;
			rec.fixed = e5 ? E5M2_MAXCODE[6:0] : E4M3_MAXCODE[6:0];
		end
	end
endmodule

FILE: test/tb.sv
module tb;
	import fp8c_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [31:0] value_in;
	logic        done;
	logic [31:0] value_out;

	logic [31:0] expected_codes[$];
	int          mismatches;
	int          results_seen;
	int          idle_cycles;
	bit          idling_on;
	int          encodes_sent;
	int          decodes_sent;

	localparam int WATCHDOG_LIMIT = 2000;

	fp8_float_converter dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .value_in(value_in), .done(done), .value_out(value_out)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// round to nearest, ties toward zero; mb mantissa bits
	function automatic logic [7:0] quantize(logic [31:0] x, int mb, int bias, int maxe,
			logic [7:0] maxcode);
		logic        sgn;
		logic [7:0]  ef;
		logic [22:0] fr;
		longint      sig;
		longint      q;
		longint      rem;
		longint      half;
		longint      code;
		int          ebits;
		int          ex;
		int          emin;
		int          eb;
		int          sh;
		sgn = x[31];
		ef = x[30:23];
		fr = x[22:0];
		if (ef == 0 && fr == 0)
			return {sgn, 7'd0};
		if (ef == 0) begin
			sig = longint'(fr);
			ebits = 1;
		end else begin
			sig = longint'({1'b1, fr});
			ebits = int'(ef);
		end
		ex = int'(ef) - 127;
		if (ex > maxe) begin
			code = longint'(maxcode);
		end else begin
			emin = 1 - bias;
			eb = (ex < emin) ? emin : ex;
			sh = (eb - mb) - (ebits - 150);
			if (sh > 40) begin
				q = 0;
			end else begin
				q = sig >> sh;
				rem = sig & ((64'd1 << sh) - 1);
				half = 64'd1 << (sh - 1);
				if (rem > half)
					q++;
			end
			code = (longint'(eb - emin) << mb) + q;
			if (code > maxcode)
				code = longint'(maxcode);
		end
		return {sgn, code[6:0]};
	endfunction

	function automatic logic [31:0] widen(logic sgn, int ex, int mant, int mb, int bias);
		int p;
		logic [7:0]  e32;
		logic [22:0] fr;
		if (ex == 0) begin
			if (mant == 0)
				return {sgn, 31'd0};
			p = mant[2] ? 2 : (mant[1] ? 1 : 0);
			e32 = 8'(p - (bias - 1) - mb + 127);
			fr = 23'((mant ^ (1 << p)) << (23 - p));
		end else begin
			e32 = 8'(ex - bias + 127);
			fr = 23'(mant << (23 - mb));
		end
		return {sgn, e32, fr};
	endfunction

	function automatic logic [31:0] convert(mode_t m, logic [31:0] v);
		logic [7:0] c;
		logic nan_in;
		logic inf_in;
		nan_in = v[30:23] == 8'hFF && v[22:0] != 0;
		inf_in = v[30:23] == 8'hFF && v[22:0] == 0;
		c = v[7:0];
		case (m)
			MODE_ENC_E4M3: begin
				if (nan_in) return {24'd0, E4M3_NAN};
				if (inf_in) return {24'd0, v[31], E4M3_INF[6:0]};
				return {24'd0, quantize(v, 3, 7, 7, E4M3_MAXCODE)};
			end
			MODE_ENC_E5M2: begin
				if (nan_in) return {24'd0, E5M2_NAN};
				if (inf_in) return {24'd0, v[31], E5M2_INF[6:0]};
				return {24'd0, quantize(v, 2, 15, 15, E5M2_MAXCODE)};
			end
			MODE_DEC_E4M3: begin
				if (c[6:3] == 4'hF)
					return (c[2:0] == 3'd6) ? {c[7], FP32_INF} : FP32_QNAN;
				return widen(c[7], c[6:3], c[2:0], 3, 7);
			end
			default: begin
				if (c[6:2] == 5'h1F)
					return (c[1:0] == 2'd0) ? {c[7], FP32_INF} : FP32_QNAN;
				return widen(c[7], c[6:2], c[1:0], 2, 15);
			end
		endcase
	endfunction

	// start stays high between back to back items unless idling inserts a random gap; drain() drops it
	task automatic send_item(mode_t m, logic [31:0] v);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		start <= 1'b1;
		mode <= m;
		value_in <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_codes.push_back(convert(m, v));
		if (m == MODE_ENC_E4M3 || m == MODE_ENC_E5M2)
			encodes_sent++;
		else
			decodes_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (expected_codes.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (expected_codes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", value_out);
			end else begin
				if (value_out !== expected_codes[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("value_out: expected %h got %h",
							expected_codes[0], value_out);
				end
				void'(expected_codes.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic test_encode_specials();
		logic [31:0] pats[$];
		pats = {32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h4370_0000,
			32'h4378_0000, 32'h4780_0000, 32'h0000_0001, 32'h807F_FFFF,
			32'h3B00_0000, 32'h3B00_0001, 32'h3780_0000};
		foreach (pats[i]) begin
			send_item(MODE_ENC_E4M3, pats[i]);
			send_item(MODE_ENC_E5M2, pats[i]);
		end
	endtask

	task automatic test_decode_all_codes();
		for (int c = 0; c < 256; c++) begin
			send_item(MODE_DEC_E4M3, {24'($urandom_range(0, 32'hFFFFFF)), c[7:0]});
			send_item(MODE_DEC_E5M2, {24'($urandom_range(0, 32'hFFFFFF)), c[7:0]});
		end
	endtask

	// random modes; any word, exponent 100..150 or 0..3, or E5M2 decodes nudged by -4..+4 ulps
	task automatic test_random(int n);
		logic [31:0] v;
		mode_t m;
		for (int i = 0; i < n; i++) begin
			m = mode_t'($urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: v = $urandom;
				1: v = {1'($urandom_range(0, 1)), 8'($urandom_range(100, 150)),
					23'($urandom)};
				2: v = {1'($urandom_range(0, 1)), 8'($urandom_range(0, 3)), 23'($urandom)};
				default: v = convert(MODE_DEC_E5M2, $urandom_range(0, 255))
					+ $urandom_range(0, 8) - 4;
			endcase
			send_item(m, v);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_ENC_E4M3;
		value_in = '0;
		mismatches = 0;
		results_seen = 0;
		idle_cycles = 0;
		idling_on = 1'b1;
		encodes_sent = 0;
		decodes_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_encode_specials();
		drain();
		test_decode_all_codes();
		drain();
		test_random(700);
		idling_on = 1'b0;
		test_random(200);
		drain();
		repeat (10) @(negedge clk);
		$display("covered %0d encode and %0d decode items, %0d results checked",
			encodes_sent, decodes_sent, results_seen);
		if (mismatches == 0 && expected_codes.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

FILE: filelist.f
sv/fp8c_pkg.sv
sv/fp8c_decode.sv
sv/fp8c_enc_prep.sv
sv/fp8_float_converter.sv
test/tb.sv
